// File: rtl/blfa_pkg.sv
// shared constants, types and discharge curve for the battery level block
package blfa_pkg;

  localparam int CURVE_POINTS = 21;
  localparam int IDX_W        = $clog2(CURVE_POINTS);
  localparam int LEVEL_W      = 14;
  localparam int MV_W         = 13;
  localparam int ADC_W        = 16;
  localparam int OHM_W        = 24;
  localparam int BATT_W       = 31;
  localparam int DIV_W        = ADC_W + OHM_W + 1;
  localparam int CNT_W        = $clog2(DIV_W + 1);
  localparam int MUL_A_W      = OHM_W + 1;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_LOW  = 2'd1;

  localparam logic [OHM_W-1:0] DIVIDER_HIGH_RESET = 24'd1500000;
  localparam logic [OHM_W-1:0] DIVIDER_LOW_RESET  = 24'd180000;
  localparam logic [OHM_W-1:0] HUNDRED            = 24'd100;

  // pass lengths of the serial divider, in quotient bits
  localparam logic [CNT_W-1:0] SCALE_BITS  = CNT_W'(DIV_W);
  localparam logic [CNT_W-1:0] VOLT_BITS   = CNT_W'(BATT_W);
  localparam logic [CNT_W-1:0] INTERP_BITS = CNT_W'(LEVEL_W + MV_W);
  localparam logic [CNT_W-1:0] PCT_BITS    = CNT_W'(LEVEL_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_MUL,
    ST_SCALE_DIV,
    ST_VOLT_DIV,
    ST_SEARCH,
    ST_INTERP_MUL,
    ST_INTERP_DIV,
    ST_PCT_DIV,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  function automatic logic [LEVEL_W-1:0] curve_level(input logic [IDX_W-1:0] idx);
    logic [LEVEL_W-1:0] v;
    case (idx)
      5'd0:    v = 14'd10000;
      5'd1:    v = 14'd9500;
      5'd2:    v = 14'd9000;
      5'd3:    v = 14'd8500;
      5'd4:    v = 14'd8000;
      5'd5:    v = 14'd7500;
      5'd6:    v = 14'd7000;
      5'd7:    v = 14'd6500;
      5'd8:    v = 14'd6000;
      5'd9:    v = 14'd5500;
      5'd10:   v = 14'd5000;
      5'd11:   v = 14'd4500;
      5'd12:   v = 14'd4000;
      5'd13:   v = 14'd3500;
      5'd14:   v = 14'd3000;
      5'd15:   v = 14'd2500;
      5'd16:   v = 14'd2000;
      5'd17:   v = 14'd1500;
      5'd18:   v = 14'd1000;
      5'd19:   v = 14'd500;
      5'd20:   v = 14'd0;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic [MV_W-1:0] curve_mv(input logic [IDX_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      5'd0:    v = 13'd4200;
      5'd1:    v = 13'd4150;
      5'd2:    v = 13'd4110;
      5'd3:    v = 13'd4080;
      5'd4:    v = 13'd4020;
      5'd5:    v = 13'd3980;
      5'd6:    v = 13'd3950;
      5'd7:    v = 13'd3910;
      5'd8:    v = 13'd3870;
      5'd9:    v = 13'd3850;
      5'd10:   v = 13'd3840;
      5'd11:   v = 13'd3820;
      5'd12:   v = 13'd3800;
      5'd13:   v = 13'd3790;
      5'd14:   v = 13'd3770;
      5'd15:   v = 13'd3750;
      5'd16:   v = 13'd3730;
      5'd17:   v = 13'd3710;
      5'd18:   v = 13'd3690;
      5'd19:   v = 13'd3610;
      5'd20:   v = 13'd3270;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/battery_level_from_adc.sv
// top level: battery voltage and charge level from one divider-tap adc reading
//
// input channel: in_valid / in_stall with adc_millivolts. in_stall is high
// while a reading is being worked on; a new word is taken only when the
// sequencer is idle.
// output channel: out_valid / out_stall with battery_millivolts,
// voltage_attribute, level_hundredths, level_percent and percent_attribute.
// the result sits in an output register, so the next reading can be taken
// while the receiver stalls; that reading then waits at its last step until
// the output register frees up.
// one word goes through up to four serial divider passes of 41, 31, 27 and 14
// bits at one bit a cycle, a curve search and the ST_SCALE_MUL and ST_INTERP_MUL
// multiply states. at or above the curve
// top the search and interpolation are skipped, below the bottom only the
// interpolation. the next word can be taken in the same cycle that out_valid rises.
// config: cfg_write with cfg_index and cfg_data writes a divider resistor;
// write only while idle. unknown indexes are ignored.
// reset: rst, synchronous; resistors return to 1500000 and 180000 ohms,
// pending work and any result in the output register are dropped.
module battery_level_from_adc (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [blfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blfa_pkg::OHM_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [blfa_pkg::ADC_W-1:0]       adc_millivolts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [blfa_pkg::BATT_W-1:0]      battery_millivolts,
  output logic [7:0]                       voltage_attribute,
  output logic [blfa_pkg::LEVEL_W-1:0]     level_hundredths,
  output logic [6:0]                       level_percent,
  output logic [7:0]                       percent_attribute
);

  localparam logic [blfa_pkg::IDX_W-1:0] LAST_IDX =
    blfa_pkg::IDX_W'(blfa_pkg::CURVE_POINTS - 1);

  blfa_pkg::state_t state, state_next;
  logic             launched, launched_next;
  logic             out_valid_next;

  logic [blfa_pkg::OHM_W-1:0]   divider_high;
  logic [blfa_pkg::OHM_W-1:0]   divider_low;

  logic [blfa_pkg::ADC_W-1:0]   adc;
  logic [blfa_pkg::DIV_W-1:0]   prod;
  logic [blfa_pkg::BATT_W-1:0]  batt;
  logic [7:0]                   volt_attr;
  logic [blfa_pkg::LEVEL_W-1:0] level;
  logic [blfa_pkg::LEVEL_W-1:0] base;
  logic [blfa_pkg::LEVEL_W-1:0] dlevel;
  logic [blfa_pkg::MV_W-1:0]    delta;
  logic [blfa_pkg::MV_W-1:0]    dmv;
  logic [6:0]                   pct;
  logic [blfa_pkg::IDX_W-1:0]   idx;

  logic                         in_accept;
  logic                         out_free;

  logic [blfa_pkg::MUL_A_W-1:0] mul_a;
  logic [blfa_pkg::ADC_W-1:0]   mul_b;
  logic [blfa_pkg::DIV_W-1:0]   mul_out;

  blfa_pkg::div_req_t           div_req;
  logic [blfa_pkg::DIV_W-1:0]   div_dividend;
  logic [blfa_pkg::OHM_W-1:0]   div_divisor;
  logic                         div_done;
  logic [blfa_pkg::DIV_W-1:0]   div_quo;
  logic [blfa_pkg::BATT_W-1:0]  batt_sat;

  logic [blfa_pkg::LEVEL_W-1:0] lo_level, hi_level;
  logic [blfa_pkg::MV_W-1:0]    lo_mv, hi_mv;
  logic                         search_more;
  logic                         seg_flat;
  logic                         at_top;

  assign in_stall  = (state != blfa_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_high <= blfa_pkg::DIVIDER_HIGH_RESET;
      divider_low  <= blfa_pkg::DIVIDER_LOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        blfa_pkg::REG_DIVIDER_HIGH: divider_high <= cfg_data;
        blfa_pkg::REG_DIVIDER_LOW:  divider_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier, registered into prod
  always_comb begin
    if (state == blfa_pkg::ST_INTERP_MUL) begin
      mul_a = blfa_pkg::MUL_A_W'(dlevel);
      mul_b = blfa_pkg::ADC_W'(delta);
    end else begin
      mul_a = {1'b0, divider_high} + {1'b0, divider_low};
      mul_b = adc;
    end
  end
  assign mul_out = blfa_pkg::DIV_W'(mul_a) * blfa_pkg::DIV_W'(mul_b);

  // divider operands per pass, left-aligned to the pass length
  always_comb begin
    case (state)
      blfa_pkg::ST_VOLT_DIV: begin
        div_dividend = {batt, {(blfa_pkg::DIV_W - blfa_pkg::BATT_W){1'b0}}};
        div_divisor  = blfa_pkg::HUNDRED;
      end
      blfa_pkg::ST_INTERP_DIV: begin
        div_dividend = {prod[blfa_pkg::LEVEL_W+blfa_pkg::MV_W-1:0],
                        {(blfa_pkg::DIV_W - blfa_pkg::LEVEL_W - blfa_pkg::MV_W){1'b0}}};
        div_divisor  = blfa_pkg::OHM_W'(dmv);
      end
      blfa_pkg::ST_PCT_DIV: begin
        div_dividend = {level, {(blfa_pkg::DIV_W - blfa_pkg::LEVEL_W){1'b0}}};
        div_divisor  = blfa_pkg::HUNDRED;
      end
      default: begin
        div_dividend = prod;
        div_divisor  = divider_low;
      end
    endcase
  end

  blfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign batt_sat = (div_quo[blfa_pkg::DIV_W-1:blfa_pkg::BATT_W] != '0) ?
                    {blfa_pkg::BATT_W{1'b1}} : div_quo[blfa_pkg::BATT_W-1:0];

  // curve walk: idx is the lower point of the segment, idx - 1 the upper
  assign lo_level    = blfa_pkg::curve_level(idx);
  assign lo_mv       = blfa_pkg::curve_mv(idx);
  assign hi_level    = blfa_pkg::curve_level(idx - 1'b1);
  assign hi_mv       = blfa_pkg::curve_mv(idx - 1'b1);
  assign search_more = (idx < LAST_IDX) && (lo_level != '0) &&
                       (batt < blfa_pkg::BATT_W'(lo_mv));
  assign seg_flat    = (batt < blfa_pkg::BATT_W'(lo_mv)) || (hi_mv <= lo_mv) ||
                       (hi_level < lo_level);
  assign at_top      = (batt >= blfa_pkg::BATT_W'(blfa_pkg::curve_mv('0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= blfa_pkg::ST_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      launched  <= launched_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    launched_next  = launched;
    out_valid_next = out_valid && out_stall;
    div_req.start  = 1'b0;
    div_req.nbits  = blfa_pkg::SCALE_BITS;
    case (state)
      blfa_pkg::ST_IDLE: begin
        if (in_valid) state_next = blfa_pkg::ST_SCALE_MUL;
      end
      blfa_pkg::ST_SCALE_MUL: state_next = blfa_pkg::ST_SCALE_DIV;
      blfa_pkg::ST_SCALE_DIV,
      blfa_pkg::ST_VOLT_DIV,
      blfa_pkg::ST_INTERP_DIV,
      blfa_pkg::ST_PCT_DIV: begin
        case (state)
          blfa_pkg::ST_VOLT_DIV:   div_req.nbits = blfa_pkg::VOLT_BITS;
          blfa_pkg::ST_INTERP_DIV: div_req.nbits = blfa_pkg::INTERP_BITS;
          blfa_pkg::ST_PCT_DIV:    div_req.nbits = blfa_pkg::PCT_BITS;
          default:                 div_req.nbits = blfa_pkg::SCALE_BITS;
        endcase
        if (!launched) begin
          div_req.start = 1'b1;
          launched_next = 1'b1;
        end else if (div_done) begin
          launched_next = 1'b0;
          case (state)
            blfa_pkg::ST_SCALE_DIV:  state_next = blfa_pkg::ST_VOLT_DIV;
            blfa_pkg::ST_VOLT_DIV:
              state_next = at_top ? blfa_pkg::ST_PCT_DIV : blfa_pkg::ST_SEARCH;
            blfa_pkg::ST_INTERP_DIV: state_next = blfa_pkg::ST_PCT_DIV;
            default:                 state_next = blfa_pkg::ST_OUTPUT;
          endcase
        end
      end
      blfa_pkg::ST_SEARCH: begin
        if (!search_more)
          state_next = seg_flat ? blfa_pkg::ST_PCT_DIV : blfa_pkg::ST_INTERP_MUL;
      end
      blfa_pkg::ST_INTERP_MUL: state_next = blfa_pkg::ST_INTERP_DIV;
      blfa_pkg::ST_OUTPUT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = blfa_pkg::ST_IDLE;
        end
      end
      default: state_next = blfa_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      blfa_pkg::ST_IDLE: begin
        if (in_accept) adc <= adc_millivolts;
      end
      blfa_pkg::ST_SCALE_MUL,
      blfa_pkg::ST_INTERP_MUL: prod <= mul_out;
      blfa_pkg::ST_SCALE_DIV: begin
        if (launched && div_done) batt <= batt_sat;
      end
      blfa_pkg::ST_VOLT_DIV: begin
        if (launched && div_done) begin
          volt_attr <= div_quo[7:0];
          level     <= blfa_pkg::curve_level('0);
          idx       <= blfa_pkg::IDX_W'(1);
        end
      end
      blfa_pkg::ST_SEARCH: begin
        if (search_more) begin
          idx <= idx + 1'b1;
        end else begin
          level  <= lo_level;
          base   <= lo_level;
          dlevel <= hi_level - lo_level;
          delta  <= batt[blfa_pkg::MV_W-1:0] - lo_mv;
          dmv    <= hi_mv - lo_mv;
        end
      end
      blfa_pkg::ST_INTERP_DIV: begin
        if (launched && div_done) level <= base + div_quo[blfa_pkg::LEVEL_W-1:0];
      end
      blfa_pkg::ST_PCT_DIV: begin
        if (launched && div_done) pct <= div_quo[6:0];
      end
      blfa_pkg::ST_OUTPUT: begin
        if (out_free) begin
          battery_millivolts <= batt;
          voltage_attribute  <= volt_attr;
          level_hundredths   <= level;
          level_percent      <= pct;
          percent_attribute  <= {pct, 1'b0};
        end
      end
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == blfa_pkg::ST_SCALE_MUL)
    else $error("accepted word did not start the multiply");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level_hundredths <= 14'd10000)
    else $error("level above full scale");

  a_full_percent: assert property (@(posedge clk) disable iff (rst)
    out_valid && level_hundredths == 14'd10000 |-> level_percent == 7'd100)
    else $error("full level without full percent");

  a_div_in_pass: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == blfa_pkg::ST_SCALE_DIV || state == blfa_pkg::ST_VOLT_DIV ||
                 state == blfa_pkg::ST_INTERP_DIV || state == blfa_pkg::ST_PCT_DIV)
    else $error("divider finished outside a division pass");

endmodule

// File: rtl/blfa_div.sv
// restoring serial divider, one quotient bit per cycle, dividend left-aligned
module blfa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  blfa_pkg::div_req_t          req,
  input  logic [blfa_pkg::DIV_W-1:0]  dividend,
  input  logic [blfa_pkg::OHM_W-1:0]  divisor,
  output logic                        done,
  output logic [blfa_pkg::DIV_W-1:0]  quotient
);

  logic                         busy;
  logic [blfa_pkg::CNT_W-1:0]   cnt;
  logic [blfa_pkg::OHM_W-1:0]   rem;
  logic [blfa_pkg::DIV_W-1:0]   quo;
  logic [blfa_pkg::OHM_W:0]     trial;
  logic [blfa_pkg::OHM_W:0]     diff;
  logic                         qbit;

  assign trial = {rem, quo[blfa_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == blfa_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      quo <= {quo[blfa_pkg::DIV_W-2:0], qbit};
      // a zero divisor keeps every bit set, which saturates upstream
      rem <= qbit ? diff[blfa_pkg::OHM_W-1:0] : trial[blfa_pkg::OHM_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

// File: sim/tb_battery_level_from_adc.sv
`timescale 1ns / 100ps
// testbench for battery_level_from_adc: directed and random readings checked by a predictor
module tb_battery_level_from_adc;

  localparam longint unsigned BATT_MAX     = 64'd2147483647;
  localparam int              DRAIN_CYCLES = 200;
  localparam int              PHASE_ITEMS  = 225;

  // indexes past the two resistors, writes there are ignored
  localparam logic [blfa_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [blfa_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [blfa_pkg::BATT_W-1:0]  batt_mv;
    logic [7:0]                   volt_attr;
    logic [blfa_pkg::LEVEL_W-1:0] level;
    logic [6:0]                   pct;
    logic [7:0]                   pct_attr;
  } reading_t;

  // lipo discharge curve, top to bottom
  int unsigned lipo_level [blfa_pkg::CURVE_POINTS] = '{
    10000, 9500, 9000, 8500, 8000, 7500, 7000, 6500, 6000, 5500, 5000,
    4500, 4000, 3500, 3000, 2500, 2000, 1500, 1000, 500, 0};
  int unsigned lipo_mv [blfa_pkg::CURVE_POINTS] = '{
    4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840,
    3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3270};

  logic                           clk;
  logic                           rst            = 1'b1;
  logic                           cfg_write      = 1'b0;
  logic [blfa_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
  logic [blfa_pkg::OHM_W-1:0]     cfg_data       = '0;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic [blfa_pkg::ADC_W-1:0]     adc_millivolts = '0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic [blfa_pkg::BATT_W-1:0]    battery_millivolts;
  logic [7:0]                     voltage_attribute;
  logic [blfa_pkg::LEVEL_W-1:0]   level_hundredths;
  logic [6:0]                     level_percent;
  logic [7:0]                     percent_attribute;

  logic [blfa_pkg::OHM_W-1:0] div_high = blfa_pkg::DIVIDER_HIGH_RESET;
  logic [blfa_pkg::OHM_W-1:0] div_low  = blfa_pkg::DIVIDER_LOW_RESET;

  logic [blfa_pkg::ADC_W-1:0] pending_adc_q [$];
  reading_t                   expected_reading_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_checked      = 0;
  int n_saturated    = 0;
  int n_settings     = 0;
  int n_fail         = 0;

  battery_level_from_adc u_top (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .adc_millivolts     (adc_millivolts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .battery_millivolts (battery_millivolts),
    .voltage_attribute  (voltage_attribute),
    .level_hundredths   (level_hundredths),
    .level_percent      (level_percent),
    .percent_attribute  (percent_attribute)
  );

  function automatic reading_t predict_reading(input logic [blfa_pkg::ADC_W-1:0] adc);
    reading_t        r;
    longint unsigned num;
    longint unsigned q;
    int unsigned     mv;
    int unsigned     lvl;
    int unsigned     pct;
    int unsigned     i;
    if (div_low == '0) begin
      q = BATT_MAX;
    end else begin
      num = 64'(adc) * (64'(div_high) + 64'(div_low));
      q = num / 64'(div_low);
      if (q > BATT_MAX) q = BATT_MAX;
    end
    mv = 32'(q);
    if (mv >= lipo_mv[0]) begin
      lvl = lipo_level[0];
    end else begin
      i = 1;
      while (i < blfa_pkg::CURVE_POINTS - 1 && lipo_level[i] > 0 && mv < lipo_mv[i]) i++;
      if (mv < lipo_mv[i]) begin
        lvl = lipo_level[i];
      end else if (lipo_mv[i-1] <= lipo_mv[i] || lipo_level[i-1] < lipo_level[i]) begin
        lvl = lipo_level[i];
      end else begin
        lvl = lipo_level[i] + ((lipo_level[i-1] - lipo_level[i]) * (mv - lipo_mv[i]))
              / (lipo_mv[i-1] - lipo_mv[i]);
      end
    end
    pct = lvl / 100;
    r.batt_mv   = mv[blfa_pkg::BATT_W-1:0];
    r.volt_attr = 8'(mv / 100);
    r.level     = lvl[blfa_pkg::LEVEL_W-1:0];
    r.pct       = pct[6:0];
    r.pct_attr  = 8'(pct * 2);
    return r;
  endfunction

  // mostly readings that land on the curve, some anywhere, some at the rails
  function automatic logic [blfa_pkg::ADC_W-1:0] random_reading();
    longint unsigned target;
    longint unsigned adc;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (pick < 70 && div_low != '0) begin
      target = $urandom_range(4300, 3200);
      adc = target * 64'(div_low) / (64'(div_high) + 64'(div_low)) + $urandom_range(1);
      if (adc > 65535) adc = 65535;
      return adc[blfa_pkg::ADC_W-1:0];
    end else if (pick < 88) begin
      return blfa_pkg::ADC_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        2:       return blfa_pkg::ADC_W'($urandom_range(15));
        default: return blfa_pkg::ADC_W'(65535 - $urandom_range(15));
      endcase
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: a word leaves the pending queue when the channel is free and the sender does not idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_reading_q.push_back(predict_reading(adc_millivolts));
      if (!in_valid || !in_stall) begin
        if (pending_adc_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          adc_millivolts <= pending_adc_q.pop_front();
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word taken from the output with the oldest prediction
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reading_q.size() == 0) begin
          $error("unexpected result word, battery_millivolts %0d", battery_millivolts);
          n_fail++;
        end else begin
          exp_r = expected_reading_q.pop_front();
          n_checked++;
          if (exp_r.batt_mv == blfa_pkg::BATT_W'(BATT_MAX)) n_saturated++;
          if (battery_millivolts !== exp_r.batt_mv) begin
            $error("battery_millivolts: expected %0d, actual %0d", exp_r.batt_mv,
                   battery_millivolts);
            n_fail++;
          end
          if (voltage_attribute !== exp_r.volt_attr) begin
            $error("voltage_attribute: expected %0d, actual %0d", exp_r.volt_attr,
                   voltage_attribute);
            n_fail++;
          end
          if (level_hundredths !== exp_r.level) begin
            $error("level_hundredths: expected %0d, actual %0d", exp_r.level, level_hundredths);
            n_fail++;
          end
          if (level_percent !== exp_r.pct) begin
            $error("level_percent: expected %0d, actual %0d", exp_r.pct, level_percent);
            n_fail++;
          end
          if (percent_attribute !== exp_r.pct_attr) begin
            $error("percent_attribute: expected %0d, actual %0d", exp_r.pct_attr,
                   percent_attribute);
            n_fail++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [blfa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [blfa_pkg::OHM_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == blfa_pkg::REG_DIVIDER_HIGH) div_high = data;
    else if (idx == blfa_pkg::REG_DIVIDER_LOW) div_low = data;
  endtask

  task automatic set_dividers(input logic [blfa_pkg::OHM_W-1:0] high,
                              input logic [blfa_pkg::OHM_W-1:0] low);
    write_reg(blfa_pkg::REG_DIVIDER_HIGH, high);
    write_reg(blfa_pkg::REG_DIVIDER_LOW, low);
    // junk on an unused index must not disturb the resistors
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, blfa_pkg::OHM_W'($urandom));
    n_settings++;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 63; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 63; end
      IDLE_BOTH:     begin send_idle_pct = 18; recv_stall_pct = 18; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic drain();
    while (pending_adc_q.size() != 0 || in_valid || expected_reading_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input logic [blfa_pkg::OHM_W-1:0] high,
                              input logic [blfa_pkg::OHM_W-1:0] low,
                              input idle_mode_t mode);
    set_dividers(high, low);
    set_idling(mode);
    for (int k = 0; k < PHASE_ITEMS; k++) pending_adc_q.push_back(random_reading());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_idling(IDLE_NONE);

    // resistors straight out of reset
    n_settings++;
    pending_adc_q.push_back('0);
    pending_adc_q.push_back('1);
    pending_adc_q.push_back(blfa_pkg::ADC_W'(450));
    drain();

    // unity divider: the reading is the battery voltage, hit every curve point
    set_dividers('0, blfa_pkg::OHM_W'(1));
    for (int k = 0; k < blfa_pkg::CURVE_POINTS; k++)
      pending_adc_q.push_back(blfa_pkg::ADC_W'(lipo_mv[k]));
    pending_adc_q.push_back(blfa_pkg::ADC_W'(3269));
    drain();

    // scaled value past the 31-bit range
    set_dividers('1, blfa_pkg::OHM_W'(1));
    pending_adc_q.push_back('1);
    drain();

    // zero lower resistor
    set_dividers(blfa_pkg::OHM_W'(5), '0);
    pending_adc_q.push_back(blfa_pkg::ADC_W'(12345));
    drain();

    random_phase(blfa_pkg::DIVIDER_HIGH_RESET, blfa_pkg::DIVIDER_LOW_RESET, IDLE_NONE);
    random_phase(blfa_pkg::OHM_W'($urandom_range(3000000, 500000)),
                 blfa_pkg::OHM_W'($urandom_range(400000, 50000)), IDLE_SENDER);
    random_phase('1, '1, IDLE_RECEIVER);
    random_phase('0, '1, IDLE_BOTH);
    random_phase('1, blfa_pkg::OHM_W'(1), IDLE_NONE);
    random_phase(blfa_pkg::OHM_W'($urandom), blfa_pkg::OHM_W'($urandom_range(16777215, 1)),
                 IDLE_SENDER);
    random_phase(blfa_pkg::OHM_W'(100000), blfa_pkg::OHM_W'(100000), IDLE_RECEIVER);
    random_phase(blfa_pkg::OHM_W'($urandom_range(2000000, 1000000)),
                 blfa_pkg::OHM_W'($urandom_range(250000, 120000)), IDLE_BOTH);

    $display("checked %0d readings over %0d divider settings, %0d of them saturated",
             n_checked, n_settings, n_saturated);
    $display("settings covered zero, unity, maximum and typical resistor values");
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("timeout with %0d results still expected", expected_reading_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
rtl/blfa_pkg.sv
rtl/blfa_div.sv
rtl/battery_level_from_adc.sv
sim/tb_battery_level_from_adc.sv
